[sv/tlo_pkg.sv]
`default_nettype none
package tlo_pkg;

    localparam int NumLabelsDef = 10;
    localparam int MaxCharsDef  = 32;
    localparam int FontCharsDef = 256;

    typedef enum logic [2:0] {
        CMD_QUERY  = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_LENGTH = 3'd2,
        CMD_VIS    = 3'd3,
        CMD_COLOR  = 3'd4,
        CMD_CHAR   = 3'd5,
        CMD_FONT   = 3'd6,
        CMD_NONE   = 3'd7
    } cmd_t;

    localparam logic [1:0] ADDR_BG = 2'd0;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  label_index;
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic [3:0]  scale;
        logic [3:0]  spacing;
        logic [15:0] color;
        logic        visible;
        logic [5:0]  length;
        logic [4:0]  offset;
        logic [7:0]  char_code;
        logic [7:0]  row_bits;
    } in_word_t;

    typedef struct packed {
        logic [15:0] pixel_color;
        logic [3:0]  slot;
        logic        table_full;
        logic        repaint;
        logic [9:0]  rect_x;
        logic [9:0]  rect_y;
        logic [12:0] rect_w;
        logic [6:0]  rect_h;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LBL,
        ST_DIV,
        ST_CHR,
        ST_FNT,
        ST_BIT,
        ST_NEXT,
        ST_RECT1,
        ST_RECT2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic lbl_setup;
        logic div_step;
        logic fnt_read;
        logic bit_eval;
        logic next_lbl;
        logic rect1;
        logic rect2;
        logic finish;
    } ctl_t;

    typedef struct packed {
        logic is_query;
        logic lbl_hit;
        logic div_done;
        logic chr_ok;
        logic last_lbl;
        logic need_rect;
    } sts_t;

endpackage
`default_nettype wire

[sv/tlo_ram.sv]
`default_nettype none
module tlo_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[sv/tlo_ctrl.sv]
`default_nettype none
module tlo_ctrl
    import tlo_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire sts_t sts,
    output ctl_t      ctl
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_DECODE;
            ST_DECODE:
            begin
                priority if (sts.is_query) state_next = ST_LBL;
                else if (sts.need_rect)    state_next = ST_RECT1;
                else                       state_next = ST_DONE;
            end
            ST_LBL:    state_next = sts.lbl_hit ? ST_DIV : ST_NEXT;
            ST_DIV:
            begin
                if (sts.div_done) state_next = sts.chr_ok ? ST_CHR : ST_NEXT;
            end
            ST_CHR:    state_next = ST_FNT;
            ST_FNT:    state_next = ST_BIT;
            ST_BIT:    state_next = ST_NEXT;
            ST_NEXT:   state_next = sts.last_lbl ? ST_DONE : ST_LBL;
            ST_RECT1:  state_next = ST_RECT2;
            ST_RECT2:  state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl           = '0;
        ctl.load      = (state_reg == ST_IDLE) && start;
        ctl.lbl_setup = (state_reg == ST_LBL);
        ctl.div_step  = (state_reg == ST_DIV);
        ctl.fnt_read  = (state_reg == ST_FNT);
        ctl.bit_eval  = (state_reg == ST_BIT);
        ctl.next_lbl  = (state_reg == ST_NEXT);
        ctl.rect1     = (state_reg == ST_RECT1);
        ctl.rect2     = (state_reg == ST_RECT2);
        ctl.finish    = (state_reg == ST_DONE);
        busy          = (state_reg != ST_IDLE);
    end
endmodule
`default_nettype wire

[sv/tlo_dp.sv]
`default_nettype none
module tlo_dp
    import tlo_pkg::*;
#(
    parameter int NumLabels = NumLabelsDef,
    parameter int MaxChars  = MaxCharsDef,
    parameter int FontChars = FontCharsDef
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire in_word_t    in_word,
    input  wire logic [15:0] bg_color,
    input  wire ctl_t        ctl,
    output sts_t             sts,
    output logic             done,
    output out_word_t        out_word
);
    localparam int LW  = (NumLabels > 1) ? $clog2(NumLabels) : 1;
    localparam int SD  = NumLabels * MaxChars;
    localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
    localparam int FD  = FontChars * 8;
    localparam int FAW = $clog2(FD);

    logic [9:0]  left_reg  [NumLabels];
    logic [9:0]  top_reg   [NumLabels];
    logic [3:0]  scl_reg   [NumLabels];
    logic [3:0]  gap_reg   [NumLabels];
    logic [15:0] col_reg   [NumLabels];
    logic [5:0]  len_reg   [NumLabels];
    logic [NumLabels-1:0] shown_reg, used_reg;

    in_word_t    cmd_reg;
    logic [LW-1:0] k_reg;
    logic [15:0] pix_reg;
    logic [5:0]  rlen_reg;
    logic [12:0] w1_reg;
    logic [12:0] dx_reg;
    logic [5:0]  pos_reg;
    logic [12:0] pitch_reg;
    logic [5:0]  dy_reg;
    logic [2:0]  cx_reg, cy_reg;
    logic        divph_reg;
    logic [5:0]  rem_reg;
    logic [3:0]  cnt_reg;
    logic        valid_reg;
    logic        ok_reg;
    logic        done_reg;
    out_word_t   out_reg;

    logic [3:0]  in_scl;
    logic [5:0]  in_len;
    logic        idx_ok;
    logic [LW-1:0] idx;
    logic        free_found;
    logic [LW-1:0] free_idx;
    logic        need_rect;
    logic [5:0]  rect_len;

    always_comb
    begin
        priority if (in_word.scale == 4'd0) in_scl = 4'd1;
        else if (in_word.scale > 4'd8)      in_scl = 4'd8;
        else                                in_scl = in_word.scale;
        if (32'(in_word.length) > MaxChars) in_len = 6'(MaxChars);
        else                                in_len = in_word.length;
        idx_ok = 32'(in_word.label_index) < NumLabels;
        idx    = LW'(in_word.label_index);
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NumLabels - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = LW'(i);
            end
        end
    end

    always_comb
    begin
        need_rect = 1'b0;
        rect_len  = len_reg[k_reg];
        unique case (cmd_t'(cmd_reg.command))
            CMD_ADD:    need_rect = valid_reg;
            CMD_LENGTH,
            CMD_VIS,
            CMD_COLOR,
            CMD_CHAR:   need_rect = valid_reg;
            default:    need_rect = 1'b0;
        endcase
        rect_len = rlen_reg;
    end

    // label walk
    logic [LW-1:0] lk;
    logic [10:0]   ybot;
    logic          hit;
    assign lk   = k_reg;
    assign ybot = 11'(top_reg[lk]) + 11'({scl_reg[lk], 3'b000});
    assign hit  = shown_reg[lk] && (cmd_reg.pos_x >= left_reg[lk])
                  && (cmd_reg.pos_y >= top_reg[lk])
                  && (11'(cmd_reg.pos_y) < ybot);

    logic [12:0] sub_dx;
    logic [5:0]  sub_rem;
    assign sub_dx  = dx_reg - pitch_reg;
    assign sub_rem = rem_reg - 6'(scl_reg[lk]);

    logic [SAW-1:0] s_waddr, s_raddr;
    logic [FAW-1:0] f_waddr, f_raddr;
    logic [7:0]     s_rdata, f_rdata;
    logic           s_we, f_we;

    assign s_we    = ctl.load && (cmd_t'(in_word.command) == CMD_CHAR) && idx_ok
                     && (32'(in_word.offset) < MaxChars);
    assign s_waddr = SAW'(32'(idx) * MaxChars + 32'(in_word.offset));
    assign s_raddr = SAW'(32'(lk) * MaxChars + 32'(pos_reg));
    assign f_we    = ctl.load && (cmd_t'(in_word.command) == CMD_FONT)
                     && (in_word.offset < 5'd8) && (32'(in_word.char_code) < FontChars);
    assign f_waddr = FAW'({in_word.char_code, in_word.offset[2:0]});
    assign f_raddr = FAW'({s_rdata, cy_reg});

    // command reports a repaint rectangle
    logic load_rect;

    always_comb
    begin
        unique case (cmd_t'(in_word.command))
            CMD_ADD:    load_rect = free_found;
            CMD_LENGTH: load_rect = idx_ok;
            CMD_VIS:    load_rect = idx_ok && (shown_reg[idx] != in_word.visible);
            CMD_COLOR:  load_rect = idx_ok && (col_reg[idx] != in_word.color);
            CMD_CHAR:   load_rect = s_we;
            default:    load_rect = 1'b0;
        endcase
    end

    tlo_ram #(.Width(8), .Depth(SD)) u_str (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(in_word.char_code),
        .raddr(s_raddr), .rdata(s_rdata)
    );
    tlo_ram #(.Width(8), .Depth(FD)) u_fnt (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(in_word.row_bits),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    logic code_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumLabels; i++)
            begin
                left_reg[i] <= '0;
                top_reg[i]  <= '0;
                scl_reg[i]  <= 4'd1;
                gap_reg[i]  <= '0;
                col_reg[i]  <= '0;
                len_reg[i]  <= '0;
            end
            shown_reg <= '0;
            used_reg  <= '0;
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.finish;
            if (ctl.load)
            begin
                valid_reg <= load_rect;
                unique case (cmd_t'(in_word.command))
                    CMD_ADD:
                    begin
                        if (free_found)
                        begin
                            left_reg[free_idx] <= in_word.pos_x;
                            top_reg[free_idx]  <= in_word.pos_y;
                            scl_reg[free_idx]  <= in_scl;
                            gap_reg[free_idx]  <= in_word.spacing;
                            col_reg[free_idx]  <= in_word.color;
                            len_reg[free_idx]  <= in_len;
                            shown_reg[free_idx] <= 1'b1;
                            used_reg[free_idx]  <= 1'b1;
                        end
                    end
                    CMD_LENGTH:
                    begin
                        if (idx_ok)
                        begin
                            len_reg[idx] <= in_len;
                        end
                    end
                    CMD_VIS:
                    begin
                        if (idx_ok && (shown_reg[idx] != in_word.visible))
                        begin
                            shown_reg[idx] <= in_word.visible;
                        end
                    end
                    CMD_COLOR:
                    begin
                        if (idx_ok && (col_reg[idx] != in_word.color))
                        begin
                            col_reg[idx] <= in_word.color;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= in_word;
            pix_reg <= bg_color;
            out_reg <= '0;
            unique case (cmd_t'(in_word.command))
                CMD_ADD:
                begin
                    k_reg    <= free_idx;
                    rlen_reg <= in_len;
                end
                CMD_LENGTH:
                begin
                    k_reg    <= idx;
                    rlen_reg <= (in_len > len_reg[idx]) ? in_len : len_reg[idx];
                end
                CMD_VIS, CMD_COLOR, CMD_CHAR:
                begin
                    k_reg    <= idx;
                    rlen_reg <= len_reg[idx];
                end
                default:
                begin
                    k_reg    <= '0;
                    rlen_reg <= '0;
                end
            endcase
        end
        if (ctl.lbl_setup)
        begin
            dx_reg    <= 13'(cmd_reg.pos_x - left_reg[lk]);
            dy_reg    <= 6'(cmd_reg.pos_y - top_reg[lk]);
            pitch_reg <= 13'((5'd8 + 5'(gap_reg[lk])) * 9'(scl_reg[lk]));
            pos_reg   <= '0;
            divph_reg <= 1'b0;
            cnt_reg   <= '0;
            ok_reg    <= 1'b1;
        end
        if (ctl.div_step)
        begin
            if (!divph_reg)
            begin
                // stop at the string end, past it the label draws nothing
                if ((dx_reg >= pitch_reg) && (pos_reg < len_reg[lk]))
                begin
                    dx_reg  <= sub_dx;
                    pos_reg <= pos_reg + 6'd1;
                end
                else
                begin
                    divph_reg <= 1'b1;
                    rem_reg   <= 6'(dx_reg);
                    if ((32'(pos_reg) >= 32'(len_reg[lk])) || (32'(pos_reg) >= MaxChars)
                        || (dx_reg >= 13'({scl_reg[lk], 3'b000})))
                    begin
                        ok_reg  <= 1'b0;
                        cnt_reg <= 4'd9;
                    end
                    else
                    begin
                        cnt_reg <= '0;
                    end
                end
            end
            else
            begin
                if (cnt_reg[3] == 1'b0)
                begin
                    if (rem_reg >= 6'(scl_reg[lk]))
                    begin
                        rem_reg <= sub_rem;
                        cx_reg  <= cx_reg + 3'd1;
                    end
                    else
                    begin
                        cnt_reg <= 4'd8;
                        rem_reg <= dy_reg;
                    end
                end
                else if (rem_reg >= 6'(scl_reg[lk]))
                begin
                    rem_reg <= sub_rem;
                    cy_reg  <= cy_reg + 3'd1;
                end
                else
                begin
                    cnt_reg <= 4'd9;
                end
            end
        end
        if (ctl.lbl_setup)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
        end
        if (ctl.fnt_read)
        begin
            code_ok_reg <= 32'(s_rdata) < FontChars;
        end
        if (ctl.bit_eval)
        begin
            if (code_ok_reg && f_rdata[3'd7 - cx_reg])
            begin
                pix_reg <= col_reg[lk];
            end
        end
        if (ctl.next_lbl)
        begin
            k_reg <= k_reg + LW'(1);
        end
        if (ctl.rect1)
        begin
            w1_reg <= 13'(rect_len) * 13'(5'd8 + 5'(gap_reg[lk]));
        end
        if (ctl.rect2)
        begin
            out_reg.repaint <= 1'b1;
            out_reg.rect_x  <= left_reg[lk];
            out_reg.rect_y  <= top_reg[lk];
            out_reg.rect_w  <= 13'(w1_reg * scl_reg[lk]);
            out_reg.rect_h  <= 7'({scl_reg[lk], 3'b000});
            out_reg.slot    <= (cmd_t'(cmd_reg.command) == CMD_ADD) ? 4'(lk) : 4'd0;
        end
        if (ctl.finish)
        begin
            if (cmd_t'(cmd_reg.command) == CMD_QUERY)
            begin
                out_reg.pixel_color <= pix_reg;
            end
            if ((cmd_t'(cmd_reg.command) == CMD_ADD) && !valid_reg)
            begin
                out_reg.table_full <= 1'b1;
            end
        end
    end

    always_comb
    begin
        sts.is_query  = (cmd_t'(cmd_reg.command) == CMD_QUERY);
        sts.lbl_hit   = hit;
        sts.div_done  = (cnt_reg == 4'd9);
        sts.chr_ok    = ok_reg;
        sts.last_lbl  = (32'(k_reg) == NumLabels - 1);
        sts.need_rect = need_rect;
    end

    assign done     = done_reg;
    assign out_word = out_reg;
endmodule
`default_nettype wire

[sv/text_label_overlay_core.sv]
// channel | signals                                  | direction
// command | start, busy, cmd (in_word_t)             | in
// result  | done, result (out_word_t)                | out
// config  | psel, penable, pwrite, paddr, pwdata...  | in/out
// a query walks every label: a miss only checks the label and moves on; a hit adds a
// pitch divide of up to 33 steps, column and row divides of up to 8 steps each, then
// string and font reads
// the result strobe rises in the same cycle that busy drops and cannot be stalled
// reset clears the label table and the background color; stores are undefined
`default_nettype none
module text_label_overlay_core
    import tlo_pkg::*;
#(
    parameter int NumLabels = NumLabelsDef,
    parameter int MaxChars  = MaxCharsDef,
    parameter int FontChars = FontCharsDef
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire in_word_t    cmd,
    output logic             done,
    output out_word_t        result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [15:0] bg_reg;
    ctl_t ctl;
    sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_BG))
        begin
            bg_reg <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BG) ? {16'd0, bg_reg} : 32'd0;

    tlo_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
    );

    tlo_dp #(.NumLabels(NumLabels), .MaxChars(MaxChars), .FontChars(FontChars)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_word(cmd), .bg_color(bg_reg),
        .ctl(ctl), .sts(sts), .done(done), .out_word(result)
    );

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result outside idle");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accept did not go busy");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("double result");
`endif
endmodule
`default_nettype wire
